>>> design/byte_level_token_text_decoder_core_assert.svh
// Assertion macros shared by the byte-level text decoder RTL.
`ifndef BYTE_LEVEL_TOKEN_TEXT_DECODER_CORE_ASSERT_SVH
`define BYTE_LEVEL_TOKEN_TEXT_DECODER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BLTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BLTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/bltd_pkg.sv
// Types, constants and decode functions of the byte-level text decoder.
package bltd_pkg;

  localparam int unsigned MaxResults = 2;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrW       = $clog2(FifoDepth);
  localparam int unsigned FillW      = $clog2(FifoDepth + 1);
  localparam int unsigned HeldDepth  = 3;

  localparam logic [20:0] ReplacementCp = 21'h00FFFD;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } map_t;

  typedef struct packed {
    logic       last_of_run;
    logic       stream_end;
    logic       byte_valid;
    logic [7:0] out_byte;
  } res_t;

  // Sequence length set by a lead byte; stray bytes count as one.
  function automatic logic [2:0] lead_len(logic [7:0] b);
    if (b < 8'h80)                     return 3'd1;
    else if ((b & 8'hE0) == 8'hC0)     return 3'd2;
    else if ((b & 8'hF0) == 8'hE0)     return 3'd3;
    else if ((b & 8'hF8) == 8'hF0)     return 3'd4;
    else                               return 3'd1;
  endfunction

  // Lenient decode: continuation bytes are not checked.
  function automatic logic [20:0] decode_cp(logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2, logic [7:0] b3,
                                            logic [2:0] avail);
    if (b0 < 8'h80)
      return {13'd0, b0};
    else if ((b0 & 8'hE0) == 8'hC0 && avail >= 3'd2)
      return {10'd0, b0[4:0], b1[5:0]};
    else if ((b0 & 8'hF0) == 8'hE0 && avail >= 3'd3)
      return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
    else if ((b0 & 8'hF8) == 8'hF0 && avail >= 3'd4)
      return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    else
      return ReplacementCp;
  endfunction

  // Inverse of the byte-to-unicode table.
  function automatic map_t inv_map(logic [20:0] cp);
    map_t       m;
    logic [6:0] n;
    m = '0;
    n = cp[6:0];
    if (cp < 21'h100) begin
      m.value = cp[7:0];
      m.ok = (cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
             (cp >= 21'hAE);
    end else if (cp < 21'h180) begin
      if (n <= 7'd32) begin
        m.ok    = 1'b1;
        m.value = {1'b0, n};
      end else if (n <= 7'd66) begin
        m.ok    = 1'b1;
        m.value = {1'b0, n} + 8'h5E;
      end else if (n == 7'd67) begin
        m.ok    = 1'b1;
        m.value = 8'hAD;
      end
    end
    return m;
  endfunction

endpackage

>>> design/byte_level_token_text_decoder_core.sv
// Byte-level token text decoder: UTF-8 regrouping, inverse byte map, result queue.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[7:0] in_byte, tlast end_of_input
//  m_axis    out  tvalid/tready          tdata[7:0] out_byte, tuser[0] byte_valid,
//                                        tuser[1] last_of_run, tlast stream_end
//
// One byte is accepted per cycle while s_axis_tready is high; its results (zero to two) enter a four-entry
// result queue in the same edge, and the queue's head drives m_axis.
// Input ready is high while the queue has room for two results, so a stream
// yielding one result per byte runs at one byte per cycle while m_axis_tready stays high.
// A byte causing two results needs a separate m_axis transfer for each result.
// Reset clears the sequence state and empties the queue.
module byte_level_token_text_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] last_of_run
  output logic       m_axis_tlast    // stream_end
);
  import bltd_pkg::*;

  logic [7:0]       held_q [HeldDepth];
  logic [7:0]       held_d [HeldDepth];
  logic [1:0]       cnt_q, cnt_d;
  logic [2:0]       need_q, need_d;

  res_t             fifo_q [FifoDepth];
  logic [PtrW-1:0]  rd_ptr_q, wr_ptr_q;
  logic [FillW-1:0] fill_q, fill_d;

  logic             s_accept, m_accept;
  logic [1:0]       push_n;
  res_t             res0, res1;

  map_t             main_m, fa_m, fb_m;
  logic [7:0]       din, seq_b1, seq_b2, f1, f2;
  logic [1:0]       rest, n;

  assign din      = s_axis_tdata;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  assign seq_b1 = (cnt_q == 2'd1) ? din : held_q[1];
  assign seq_b2 = (cnt_q == 2'd2) ? din : held_q[2];

  always_comb begin
    cnt_d  = cnt_q;
    need_d = need_q;
    held_d = held_q;
    main_m = '0;
    fa_m   = '0;
    fb_m   = '0;
    rest   = 2'd0;
    n      = 2'd0;
    res0   = '0;
    res1   = '0;
    push_n = 2'd0;

    if (cnt_q == 2'd0) begin
      if (lead_len(din) == 3'd1) begin
        main_m = inv_map(decode_cp(din, din, din, din, 3'd1));
      end else begin
        held_d[0] = din;
        cnt_d     = 2'd1;
        need_d    = lead_len(din);
      end
    end else if ({1'b0, cnt_q} + 3'd1 >= need_q || cnt_q == 2'd3) begin
      main_m = inv_map(decode_cp(held_q[0], seq_b1, seq_b2, din, {1'b0, cnt_q} + 3'd1));
      cnt_d  = 2'd0;
      need_d = 3'd0;
    end else begin
      held_d[cnt_q] = din;
      cnt_d         = cnt_q + 2'd1;
    end

    // End of stream: drop the open lead and decode what follows it again.
    f1 = held_d[1];
    f2 = held_d[2];
    if (cnt_d == 2'd2)      rest = 2'd1;
    else if (cnt_d == 2'd3) rest = 2'd2;
    if (rest == 2'd1) begin
      fa_m = inv_map(decode_cp(f1, f1, f1, f1, 3'd1));
    end else if (rest == 2'd2) begin
      fa_m = inv_map(decode_cp(f1, f2, f2, f2, 3'd2));
      if ((f1 & 8'hE0) != 8'hC0) fb_m = inv_map(decode_cp(f2, f2, f2, f2, 3'd1));
    end

    if (main_m.ok) begin
      res0.out_byte = main_m.value;
      n = 2'd1;
    end
    if (s_axis_tlast) begin
      if (fa_m.ok) begin
        if (n == 2'd0) res0.out_byte = fa_m.value;
        else           res1.out_byte = fa_m.value;
        n = n + 2'd1;
      end
      if (fb_m.ok) begin
        if (n == 2'd0) res0.out_byte = fb_m.value;
        else           res1.out_byte = fb_m.value;
        n = n + 2'd1;
      end
      cnt_d  = 2'd0;
      need_d = 3'd0;
    end

    res0.byte_valid = (n != 2'd0);
    res1.byte_valid = 1'b1;
    if (s_axis_tlast && n == 2'd0) begin
      // bare end marker
      res0.stream_end  = 1'b1;
      res0.last_of_run = 1'b1;
      push_n           = 2'd1;
    end else begin
      push_n = n;
      if (n == 2'd1) begin
        res0.last_of_run = 1'b1;
        res0.stream_end  = s_axis_tlast;
      end else if (n == 2'd2) begin
        res1.last_of_run = 1'b1;
        res1.stream_end  = s_axis_tlast;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      need_q <= 3'd0;
    end else if (s_accept) begin
      cnt_q  <= cnt_d;
      need_q <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      held_q <= held_d;
    end
  end

  // Result queue
  assign s_axis_tready = (fill_q <= FillW'(FifoDepth - MaxResults));
  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].out_byte;
  assign m_axis_tuser  = {fifo_q[rd_ptr_q].last_of_run, fifo_q[rd_ptr_q].byte_valid};
  assign m_axis_tlast  = fifo_q[rd_ptr_q].stream_end;

  always_comb begin
    fill_d = fill_q;
    if (s_accept) fill_d = fill_d + FillW'(push_n);
    if (m_accept) fill_d = fill_d - FillW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (m_accept) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (s_accept) wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && push_n != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (s_accept && push_n == 2'd2) fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
  end

`include "byte_level_token_text_decoder_core_assert.svh"

  `BLTD_ASSERT(a_fill_bound, fill_q <= FillW'(FifoDepth), "result queue overflow")
  `BLTD_ASSERT(a_seq_consistent, (cnt_q != 2'd0) |-> ({1'b0, cnt_q} < need_q), "held count not below needed length")
  `BLTD_ASSERT(a_idle_no_need, (cnt_q == 2'd0) |-> (need_q == 3'd0), "needed length set with no held byte")
  `BLTD_ASSERT(a_end_clears, (s_accept && s_axis_tlast) |=> (cnt_q == 2'd0), "sequence state left open after end of stream")
  `BLTD_ASSERT(a_marker_closes, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tuser[1]), "bare marker is not the stream's last item")

endmodule
